// ----- rtl/core/qpr_pkg.sv -----
// ============================================================================
// qpr_pkg: shared types and constants for the quaternion point rotator
// Field widths, fixed-point formats, register indexes and the matrix type
// that passes between the coefficient unit and the datapath pipeline.
// ============================================================================
package qpr_pkg;

	// Field widths.
	localparam int CoordW  = 24;               // point and result coordinates
	localparam int RotW    = 16;               // quaternion components, Q1.14
	localparam int CfgIdxW = 4;                // configuration register index
	localparam int FracBits = 28;              // scale of the matrix entries

	// Internal widths.
	localparam int PpW   = 2 * RotW;           // product of two components
	localparam int CoefW = PpW + 2;            // matrix entry, |m| <= 2^32
	localparam int ProdW = CoefW + CoordW;     // entry times coordinate
	localparam int SumW  = ProdW + 2;          // sum of three products
	localparam int RndW  = SumW - FracBits;    // rounded coordinate before clipping

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [RotW-1:0]   rot_t;
	typedef logic signed [PpW-1:0]    pp_t;
	typedef logic signed [CoefW-1:0]  coef_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [SumW-1:0]   sum_t;
	typedef logic signed [RndW-1:0]   rnd_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_ROT_X = 4'd0,
		REG_ROT_Y = 4'd1,
		REG_ROT_Z = 4'd2,
		REG_ROT_W = 4'd3
	} cfg_reg_t;

	// Reset quaternion is the identity: w = 1.0 in Q1.14.
	localparam rot_t  RotWReset = rot_t'(1) <<< (RotW - 2);
	localparam pp_t   PpOne     = pp_t'(1) <<< FracBits;
	localparam coef_t CoefOne   = coef_t'(1) <<< FracBits;

	// Round to nearest, ties toward plus infinity.
	localparam sum_t RoundBias = sum_t'(1) <<< (FracBits - 1);

	// Saturation limits of an output coordinate.
	localparam coord_t CoordMax = coord_t'({1'b0, {(CoordW - 1){1'b1}}});
	localparam coord_t CoordMin = coord_t'({1'b1, {(CoordW - 1){1'b0}}});

	// Rotation matrix, entry [row][col], each a signed coef_t scaled by 2^28.
	typedef struct packed {
		logic [2:0][2:0][CoefW-1:0] m;
	} rot_mat_t;

endpackage

// ----- rtl/core/qpr_if.sv -----
// ============================================================================
// qpr_if: channel interfaces of the quaternion point rotator
// Point input channel, result output channel and configuration write
// channel, each a valid/ready handshake with its payload.
// ============================================================================
interface qpr_point_if;
	logic           valid;
	logic           ready;
	qpr_pkg::coord_t point_x;
	qpr_pkg::coord_t point_y;
	qpr_pkg::coord_t point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

interface qpr_result_if;
	logic            valid;
	logic            ready;
	qpr_pkg::coord_t out_x;
	qpr_pkg::coord_t out_y;
	qpr_pkg::coord_t out_z;
	logic            saturated;

	modport source (output valid, output out_x, output out_y, output out_z,
		output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input saturated, output ready);
endinterface

interface qpr_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [qpr_pkg::CfgIdxW-1:0]  index;
	qpr_pkg::rot_t                data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/quaternion_point_rotator_top.sv -----
// ============================================================================
// quaternion_point_rotator_top: 3-D point rotation by a unit quaternion
// Rotates each incoming point p as q * p * conj(q), evaluated through the
// equivalent 3x3 rotation matrix, rounds to nearest and saturates to 24 bits.
// ============================================================================
//
// Channel   Direction  Payload                                  Handshake
// --------  ---------  ---------------------------------------  -----------
// cfg       in         index (4 b), data (16 b, Q1.14)          valid/ready
// points    in         point_x, point_y, point_z (24 b signed)  valid/ready
// results   out        out_x, out_y, out_z (24 b), saturated    valid/ready
//
// One point enters per cycle while the results channel does not stall; a result
// is offered once its transaction has passed the five-stage datapath (input,
// alignment, products, row sums, round and clip).
// The matrix follows a configuration write through the product and matrix registers,
// which the alignment stage covers, so a point may follow a write in the next cycle.
// Reset clears the pipeline valid bits and loads the identity quaternion.
// A stall on the results channel backs up stage by stage; no stage drops or
// repeats a transaction, and the input keeps taking points while any stage
// is empty.
//
module quaternion_point_rotator_top (
	input  logic         clk,
	input  logic         arst_n,
	qpr_cfg_if.sink      cfg,
	qpr_point_if.sink    points,
	qpr_result_if.source results
);

	// Rotation matrix derived from the configured quaternion. It only changes after configuration
	// writes, which the user must send while the datapath is empty; the block does not enforce it.
	qpr_pkg::rot_mat_t mat;

	// Quaternion registers and matrix computation.
	qpr_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.mat    (mat)
	);

	// Point datapath: matrix times point, rounding and saturation.
	qpr_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.mat     (mat),
		.points  (points),
		.results (results)
	);

endmodule

// ----- rtl/core/qpr_coef.sv -----
// ============================================================================
// qpr_coef: quaternion registers and rotation matrix unit
// Holds the four quaternion components and turns them into the 3x3
// rotation matrix in two register stages: component products, then sums.
// ============================================================================
module qpr_coef (
	input  logic              clk,
	input  logic              arst_n,
	qpr_cfg_if.sink           cfg,
	output qpr_pkg::rot_mat_t mat
);

	qpr_pkg::rot_t rot_x_q, rot_y_q, rot_z_q, rot_w_q;
	qpr_pkg::pp_t  ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	qpr_pkg::rot_mat_t mat_q;
	logic          ident;

	assign cfg.ready = 1'b1;
	assign mat       = mat_q;

	// Configuration writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
			rot_w_q <= qpr_pkg::RotWReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				qpr_pkg::REG_ROT_X: rot_x_q <= cfg.data;
				qpr_pkg::REG_ROT_Y: rot_y_q <= cfg.data;
				qpr_pkg::REG_ROT_Z: rot_z_q <= cfg.data;
				qpr_pkg::REG_ROT_W: rot_w_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pairwise component products. Reset loads the identity so that the
	// matrix is valid from the first cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= qpr_pkg::PpOne;
			xx_q <= '0;
			yy_q <= '0;
			zz_q <= '0;
			xy_q <= '0;
			xz_q <= '0;
			yz_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
			wz_q <= '0;
		end else begin
			ww_q <= qpr_pkg::pp_t'(rot_w_q) * qpr_pkg::pp_t'(rot_w_q);
			xx_q <= qpr_pkg::pp_t'(rot_x_q) * qpr_pkg::pp_t'(rot_x_q);
			yy_q <= qpr_pkg::pp_t'(rot_y_q) * qpr_pkg::pp_t'(rot_y_q);
			zz_q <= qpr_pkg::pp_t'(rot_z_q) * qpr_pkg::pp_t'(rot_z_q);
			xy_q <= qpr_pkg::pp_t'(rot_x_q) * qpr_pkg::pp_t'(rot_y_q);
			xz_q <= qpr_pkg::pp_t'(rot_x_q) * qpr_pkg::pp_t'(rot_z_q);
			yz_q <= qpr_pkg::pp_t'(rot_y_q) * qpr_pkg::pp_t'(rot_z_q);
			wx_q <= qpr_pkg::pp_t'(rot_w_q) * qpr_pkg::pp_t'(rot_x_q);
			wy_q <= qpr_pkg::pp_t'(rot_w_q) * qpr_pkg::pp_t'(rot_y_q);
			wz_q <= qpr_pkg::pp_t'(rot_w_q) * qpr_pkg::pp_t'(rot_z_q);
		end
	end

	// Matrix entries from the products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mat_q.m[i][j] <= (i == j) ? qpr_pkg::CoefOne : qpr_pkg::coef_t'(0);
				end
			end
		end else begin
			mat_q.m[0][0] <= qpr_pkg::coef_t'(ww_q) + qpr_pkg::coef_t'(xx_q)
				- qpr_pkg::coef_t'(yy_q) - qpr_pkg::coef_t'(zz_q);
			mat_q.m[0][1] <= (qpr_pkg::coef_t'(xy_q) - qpr_pkg::coef_t'(wz_q)) <<< 1;
			mat_q.m[0][2] <= (qpr_pkg::coef_t'(xz_q) + qpr_pkg::coef_t'(wy_q)) <<< 1;
			mat_q.m[1][0] <= (qpr_pkg::coef_t'(xy_q) + qpr_pkg::coef_t'(wz_q)) <<< 1;
			mat_q.m[1][1] <= qpr_pkg::coef_t'(ww_q) - qpr_pkg::coef_t'(xx_q)
				+ qpr_pkg::coef_t'(yy_q) - qpr_pkg::coef_t'(zz_q);
			mat_q.m[1][2] <= (qpr_pkg::coef_t'(yz_q) - qpr_pkg::coef_t'(wx_q)) <<< 1;
			mat_q.m[2][0] <= (qpr_pkg::coef_t'(xz_q) - qpr_pkg::coef_t'(wy_q)) <<< 1;
			mat_q.m[2][1] <= (qpr_pkg::coef_t'(yz_q) + qpr_pkg::coef_t'(wx_q)) <<< 1;
			mat_q.m[2][2] <= qpr_pkg::coef_t'(ww_q) - qpr_pkg::coef_t'(xx_q)
				- qpr_pkg::coef_t'(yy_q) + qpr_pkg::coef_t'(zz_q);
		end
	end

	assign ident = (rot_x_q == '0) && (rot_y_q == '0) && (rot_z_q == '0)
		&& (rot_w_q == qpr_pkg::RotWReset);

	// An identity quaternion held through the product and matrix registers yields the unit matrix.
	a_identity_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ident, 2) && $past(ident) |->
		mat_q.m[0][0] == qpr_pkg::CoefOne && mat_q.m[2][2] == qpr_pkg::CoefOne
		&& mat_q.m[0][1] == '0 && mat_q.m[2][1] == '0)
		else $error("identity quaternion did not give the unit matrix");

	// A write to an index past the last register changes nothing.
	a_stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && (cfg.index > qpr_pkg::CfgIdxW'(qpr_pkg::REG_ROT_W)) |=>
		$stable(rot_x_q) && $stable(rot_y_q) && $stable(rot_z_q) && $stable(rot_w_q))
		else $error("write to an unused register index changed the quaternion");

endmodule

// ----- rtl/core/qpr_pipe.sv -----
// ============================================================================
// qpr_pipe: point datapath pipeline
// Five register stages: input, alignment with the matrix, nine products,
// row sums with the rounding bias, and round, clip and output.
// ============================================================================
module qpr_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  qpr_pkg::rot_mat_t mat,
	qpr_point_if.sink         points,
	qpr_result_if.source      results
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	qpr_pkg::coord_t pt_s1 [3];
	qpr_pkg::coord_t pt_s2 [3];
	qpr_pkg::prod_t  pr_s3 [3][3];
	qpr_pkg::sum_t   acc_s4 [3];
	qpr_pkg::coord_t out_s5 [3];
	logic            sat_s5;

	qpr_pkg::rnd_t   rnd [3];
	qpr_pkg::coord_t clip [3];
	logic [2:0]      hit;

	// A stage loads when it is empty or its content moves on.
	assign en_s5 = !v_s5 || results.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign points.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= points.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Round by flooring the biased sum, then clip to the coordinate range.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = qpr_pkg::rnd_t'(acc_s4[i][qpr_pkg::SumW-1:qpr_pkg::FracBits]);
			if (rnd[i] > qpr_pkg::rnd_t'(qpr_pkg::CoordMax)) begin
				clip[i] = qpr_pkg::CoordMax;
				hit[i]  = 1'b1;
			end else if (rnd[i] < qpr_pkg::rnd_t'(qpr_pkg::CoordMin)) begin
				clip[i] = qpr_pkg::CoordMin;
				hit[i]  = 1'b1;
			end else begin
				clip[i] = qpr_pkg::coord_t'(rnd[i]);
				hit[i]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1[0] <= points.point_x;
			pt_s1[1] <= points.point_y;
			pt_s1[2] <= points.point_z;
		end
		// The extra stage gives a new quaternion time to reach the matrix.
		if (en_s2) begin
			pt_s2 <= pt_s1;
		end
		if (en_s3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s3[i][j] <= qpr_pkg::prod_t'($signed(mat.m[i][j]))
						* qpr_pkg::prod_t'(pt_s2[j]);
				end
			end
		end
		if (en_s4) begin
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= qpr_pkg::sum_t'(pr_s3[i][0]) + qpr_pkg::sum_t'(pr_s3[i][1])
					+ qpr_pkg::sum_t'(pr_s3[i][2]) + qpr_pkg::RoundBias;
			end
		end
		if (en_s5) begin
			out_s5 <= clip;
			sat_s5 <= |hit;
		end
	end

	assign results.valid     = v_s5;
	assign results.out_x     = out_s5[0];
	assign results.out_y     = out_s5[1];
	assign results.out_z     = out_s5[2];
	assign results.saturated = sat_s5;

	// A flagged result has at least one coordinate on a rail.
	a_sat_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && sat_s5 |->
		out_s5[0] == qpr_pkg::CoordMax || out_s5[0] == qpr_pkg::CoordMin
		|| out_s5[1] == qpr_pkg::CoordMax || out_s5[1] == qpr_pkg::CoordMin
		|| out_s5[2] == qpr_pkg::CoordMax || out_s5[2] == qpr_pkg::CoordMin)
		else $error("saturation flagged without a clipped coordinate");

	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		points.valid && points.ready |=> v_s1)
		else $error("accepted point was lost at the input stage");

	// A sum waiting behind a stalled output keeps its value.
	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s5 |=> v_s4 && $stable(acc_s4[0]) && $stable(acc_s4[2]))
		else $error("row sum changed while stalled");

	// A full fourth stage moves into the output stage when it may.
	a_s4_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && en_s5 |=> v_s5)
		else $error("row sum dropped on its way to the output stage");

endmodule
